/* rtl/ght_pkg.sv */
`default_nettype none

package ght_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam logic [1:0] KIND_REGISTER   = 2'd0;
    localparam logic [1:0] KIND_UNREGISTER = 2'd1;
    localparam logic [1:0] KIND_LOOKUP     = 2'd2;
    localparam logic [1:0] KIND_NTH        = 2'd3;

    localparam int GEN_W   = 16;
    localparam int SLOT_W  = 16;
    localparam int POS_W   = 4;
    localparam int COLOR_W = 32;
    localparam int LIVE_W  = 5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        handle;
        logic [POS_W-1:0]   position;
        logic [COLOR_W-1:0] entry_color;
        logic               entry_fullscreen;
    } ght_req_t;

    typedef struct packed {
        logic [31:0]        result_handle;
        logic               found;
        logic [COLOR_W-1:0] color;
        logic               fullscreen;
        logic [LIVE_W-1:0]  live_count;
    } ght_rsp_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               fullscreen;
    } ght_entry_t;

endpackage

`default_nettype wire

/* rtl/ght_mem.sv */
`default_nettype none

module ght_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire ght_pkg::ght_entry_t wr_data,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output ght_pkg::ght_entry_t     rd_data
);
    import ght_pkg::*;

    ght_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/generational_handle_table.sv */
`default_nettype none

// Generational handle table: SLOTS slots, one transaction in flight at a time.
// A handle is generation in bits 31..16 and slot number plus one in bits 15..0;
// handle 0 is never valid. Register and nth requests walk the slots with one
// shared compare unit, one slot per cycle. Unregister checks the slot's
// generation and goes to the result; lookup also passes through a fetch state
// for the registered read of the color/fullscreen memory, and either goes
// straight to the result when the slot field is zero or beyond SLOTS.
// req_ready is low from acceptance until the result transaction is taken.
// live_count reports slots in use after the request, saturating at 31.

module generational_handle_table #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire ght_pkg::ght_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output ght_pkg::ght_rsp_t      rsp
);
    import ght_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  seen_reg, seen_next;
    logic              hit_reg, hit_next;
    ght_req_t          req_reg, req_next;
    ght_rsp_t          res_reg, res_next;
    logic [CNT_W-1:0]  live_reg;
    logic [SLOTS-1:0]  in_use_reg;
    logic [GEN_W-1:0]  gen_reg [SLOTS];

    logic              use_set, use_clr;
    logic              mem_wr;
    ght_entry_t        mem_wdata;
    ght_entry_t        mem_rdata;
    logic [GEN_W-1:0]  gen_cur, gen_inc;
    logic              cur_used, last_slot;
    logic [SLOT_W-1:0] slot_field;
    logic [31:0]       live_ext;

    ght_mem #(
        .DEPTH (SLOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (idx_reg),
        .wr_data (mem_wdata),
        .rd_addr (idx_reg),
        .rd_data (mem_rdata)
    );

    assign gen_cur    = gen_reg[idx_reg];
    assign gen_inc    = (gen_cur == {GEN_W{1'b1}}) ? GEN_W'(1) : gen_cur + GEN_W'(1);
    assign cur_used   = in_use_reg[idx_reg];
    assign last_slot  = (32'(idx_reg) == 32'(SLOTS - 1));
    assign slot_field = SLOT_W'(32'(idx_reg) + 32'd1);
    assign mem_wdata  = '{color: req_reg.entry_color, fullscreen: req_reg.entry_fullscreen};
    assign live_ext   = 32'(live_reg);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);

    always_comb
    begin
        rsp            = res_reg;
        rsp.live_count = (live_ext > 32'd31) ? LIVE_W'(31) : live_ext[LIVE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        seen_next  = seen_reg;
        hit_next   = hit_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        use_set    = 1'b0;
        use_clr    = 1'b0;
        mem_wr     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    res_next  = '0;
                    seen_next = '0;
                    idx_next  = '0;
                    if (req.kind == KIND_REGISTER || req.kind == KIND_NTH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req.handle[SLOT_W-1:0] != '0 &&
                             32'(req.handle[SLOT_W-1:0]) <= 32'(SLOTS))
                    begin
                        idx_next   = IDX_W'(req.handle[SLOT_W-1:0] - SLOT_W'(1));
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (req_reg.kind == KIND_REGISTER)
                begin
                    if (!cur_used)
                    begin
                        use_set                = 1'b1;
                        mem_wr                 = 1'b1;
                        res_next.result_handle = {gen_inc, slot_field};
                        res_next.found         = 1'b1;
                        state_next             = ST_DONE;
                    end
                    else if (last_slot)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    if (cur_used && seen_reg == req_reg.position)
                    begin
                        res_next.result_handle = {gen_cur, slot_field};
                        res_next.found         = 1'b1;
                        state_next             = ST_DONE;
                    end
                    else if (last_slot)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (cur_used)
                        begin
                            seen_next = seen_reg + POS_W'(1);
                        end
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                hit_next = cur_used && (gen_cur == req_reg.handle[31:SLOT_W]);
                if (req_reg.kind == KIND_UNREGISTER)
                begin
                    use_clr        = hit_next;
                    res_next.found = hit_next;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                res_next.found      = hit_reg;
                res_next.color      = hit_reg ? mem_rdata.color : '0;
                res_next.fullscreen = hit_reg & mem_rdata.fullscreen;
                state_next          = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            live_reg   <= '0;
            in_use_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (use_set)
            begin
                in_use_reg[idx_reg] <= 1'b1;
                gen_reg[idx_reg]    <= gen_inc;
                live_reg            <= live_reg + CNT_W'(1);
            end
            else if (use_clr)
            begin
                in_use_reg[idx_reg] <= 1'b0;
                live_reg            <= live_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        seen_reg <= seen_next;
        hit_reg  <= hit_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
    end

`ifndef SYNTH
    a_live_matches_slots: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) == $countones(in_use_reg))
        else $error("live count disagrees with slot occupancy");

    a_new_handle_nonzero_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.found && req_reg.kind == KIND_REGISTER)
            |-> (rsp.result_handle[31:SLOT_W] != '0 && rsp.result_handle[SLOT_W-1:0] != '0))
        else $error("registered handle has zero generation or slot");

    a_miss_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.found)
            |-> (rsp.result_handle == '0 && rsp.color == '0 && !rsp.fullscreen))
        else $error("failed request returned data");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("accepted a second transaction while busy");
`endif

endmodule

`default_nettype wire

/* bench/generational_handle_table_tb.sv */
`timescale 1ns / 1ps

module generational_handle_table_tb;

    import ght_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 950;
    localparam int PHASE_ITEMS  = 95;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 2 * SLOTS + 8;
    localparam int MAX_REPORTS  = 100;
    localparam int RETIRED_KEEP = 32;

    class handle_table_scoreboard;
        bit          in_use [SLOTS];
        logic [15:0] generation [SLOTS];
        logic [31:0] color [SLOTS];
        logic        fullscreen [SLOTS];
        ght_rsp_t    expected_answers [$];
        logic [31:0] retired_handles [$];
        int          mismatches;
        int          answers_checked;
        int          kind_count [4];
        int          full_rejects;
        int          generation_wraps;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                in_use[i]     = 1'b0;
                generation[i] = 16'd0;
                color[i]      = 32'd0;
                fullscreen[i] = 1'b0;
            end
            foreach (kind_count[k])
                kind_count[k] = 0;
            mismatches       = 0;
            answers_checked  = 0;
            full_rejects     = 0;
            generation_wraps = 0;
        endfunction

        function int live_total();
            int n;
            n = 0;
            foreach (in_use[i])
                if (in_use[i])
                    n++;
            return n;
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        // slot index for a handle that names a live slot of matching generation, else -1
        function int valid_slot(logic [31:0] h);
            int idx;
            if (h[15:0] == 16'd0 || h[15:0] > SLOTS)
                return -1;
            idx = int'(h[15:0]) - 1;
            if (!in_use[idx] || generation[idx] != h[31:16])
                return -1;
            return idx;
        endfunction

        function logic [31:0] live_handle();
            int picks [$];
            int idx;
            foreach (in_use[i])
                if (in_use[i])
                    picks.push_back(i);
            if (picks.size() == 0)
                return 32'd0;
            idx = picks[$urandom_range(0, picks.size() - 1)];
            return {generation[idx], 16'(idx + 1)};
        endfunction

        function logic [31:0] stale_handle();
            if (retired_handles.size() == 0)
                return $urandom();
            return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
        endfunction

        function ght_rsp_t predict_answer(ght_req_t r);
            ght_rsp_t a;
            int       s;
            int       seen;
            a    = '0;
            s    = -1;
            seen = 0;
            kind_count[r.kind]++;
            case (r.kind)
                KIND_REGISTER:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!in_use[i] && s < 0)
                            s = i;
                    if (s < 0)
                        full_rejects++;
                    else
                    begin
                        in_use[s]     = 1'b1;
                        generation[s] = generation[s] + 16'd1;
                        if (generation[s] == 16'd0)
                        begin
                            generation[s] = 16'd1;
                            generation_wraps++;
                        end
                        color[s]        = r.entry_color;
                        fullscreen[s]   = r.entry_fullscreen;
                        a.result_handle = {generation[s], 16'(s + 1)};
                        a.found         = 1'b1;
                    end
                end
                KIND_UNREGISTER:
                begin
                    s = valid_slot(r.handle);
                    if (s >= 0)
                    begin
                        in_use[s] = 1'b0;
                        a.found   = 1'b1;
                        retired_handles.push_back(r.handle);
                        if (retired_handles.size() > RETIRED_KEEP)
                            void'(retired_handles.pop_front());
                    end
                end
                KIND_LOOKUP:
                begin
                    s = valid_slot(r.handle);
                    if (s >= 0)
                    begin
                        a.found      = 1'b1;
                        a.color      = color[s];
                        a.fullscreen = fullscreen[s];
                    end
                end
                default:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (in_use[i] && !a.found)
                        begin
                            if (seen == int'(r.position))
                            begin
                                a.result_handle = {generation[i], 16'(i + 1)};
                                a.found         = 1'b1;
                            end
                            seen++;
                        end
                    end
                end
            endcase
            a.live_count = LIVE_W'(live_total());
            return a;
        endfunction

        function void note_request(ght_req_t r);
            expected_answers.push_back(predict_answer(r));
        endfunction

        function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            else if (mismatches == MAX_REPORTS + 1)
                $display("%0t: further mismatches not shown", $time);
        endfunction

        function void check_response(ght_rsp_t got);
            ght_rsp_t want;
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response transaction, expected none, got %h", $time, got);
                return;
            end
            want = expected_answers.pop_front();
            answers_checked++;
            if (got.result_handle !== want.result_handle)
                report_mismatch("result_handle", want.result_handle, got.result_handle);
            if (got.found !== want.found)
                report_mismatch("found", want.found, got.found);
            if (got.color !== want.color)
                report_mismatch("color", want.color, got.color);
            if (got.fullscreen !== want.fullscreen)
                report_mismatch("fullscreen", want.fullscreen, got.fullscreen);
            if (got.live_count !== want.live_count)
                report_mismatch("live_count", want.live_count, got.live_count);
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    ght_req_t req;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ght_rsp_t rsp;

    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;
    bit long_hold_req   = 1'b0;
    int stall_left      = 0;
    int hold_left       = 0;
    int cycle_count     = 0;

    handle_table_scoreboard table_sb = new();

    generational_handle_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d responses outstanding",
                     $time, table_sb.pending());
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            table_sb.check_response(rsp);
    end

    // response side: one long hold on request, otherwise short random stalls while receiver_stalls is set
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (receiver_stalls && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    task automatic send_request(input ght_req_t r);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        table_sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [31:0] handle,
                               input int position, input logic [31:0] entry_color,
                               input logic entry_fullscreen);
        ght_req_t r;
        r.kind             = kind;
        r.handle           = handle;
        r.position         = POS_W'(position);
        r.entry_color      = entry_color;
        r.entry_fullscreen = entry_fullscreen;
        send_request(r);
    endtask

    task automatic drain_answers();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (table_sb.pending() != 0);
    endtask

    function automatic ght_req_t random_request(bit filling);
        ght_req_t r;
        int       pick;
        int       live;
        live               = table_sb.live_total();
        r.kind             = KIND_LOOKUP;
        r.handle           = table_sb.live_handle();
        r.position         = POS_W'($urandom_range(0, 15));
        r.entry_color      = $urandom();
        r.entry_fullscreen = 1'($urandom_range(0, 1));
        pick               = $urandom_range(0, 99);
        if (pick < (filling ? 45 : 20))
            r.kind = KIND_REGISTER;
        else if (pick < 55)
            r.kind = KIND_UNREGISTER;
        else if (pick < 72)
            r.kind = KIND_LOOKUP;
        else if (pick < 86)
        begin
            r.kind = KIND_NTH;
            if ($urandom_range(0, 2) != 0)
                r.position = POS_W'($urandom_range(0, live > 0 ? live - 1 : 0));
        end
        else
        begin
            r.kind = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_UNREGISTER;
            case ($urandom_range(0, 3))
                0:       r.handle = $urandom();
                1:       r.handle = table_sb.stale_handle();
                2:       r.handle[31:16] = 16'($urandom());
                default: r.handle[15:0] = 16'($urandom_range(SLOTS + 1, 16'hFFFF));
            endcase
            if ($urandom_range(0, 3) == 0)
                r.kind = 2'($urandom_range(0, 3));
        end
        return r;
    endfunction

    initial
    begin
        int phase;
        int total;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        phase     = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, fill to full, invalid handle shapes, double free
        send_fields(KIND_NTH, 32'd0, 0, 32'hFFFF_FFFF, 1'b1);
        send_fields(KIND_UNREGISTER, 32'd0, 0, 32'd0, 1'b0);
        for (int i = 0; i < SLOTS; i++)
            send_fields(KIND_REGISTER, 32'hFFFF_FFFF, i,
                        i == 0 ? 32'd0 : (i == 1 ? 32'hFFFF_FFFF : $urandom()), i[0]);
        send_fields(KIND_REGISTER, 32'd0, 0, 32'hA5A5_5A5A, 1'b1);
        send_fields(KIND_NTH, 32'd0, 15, 32'd0, 1'b0);
        send_fields(KIND_LOOKUP, 32'h0001_0002, 0, 32'd0, 1'b0);
        send_fields(KIND_LOOKUP, 32'h0001_0000, 0, 32'd0, 1'b0);
        send_fields(KIND_LOOKUP, {16'h0001, 16'(SLOTS + 1)}, 0, 32'd0, 1'b0);
        send_fields(KIND_LOOKUP, 32'h0002_0001, 0, 32'd0, 1'b0);
        send_fields(KIND_UNREGISTER, 32'h0001_0001, 0, 32'd0, 1'b0);
        send_fields(KIND_UNREGISTER, 32'h0001_0001, 0, 32'd0, 1'b0);
        send_fields(KIND_NTH, 32'd0, 15, 32'd0, 1'b0);
        drain_answers();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                phase           = n / PHASE_ITEMS;
                sender_gaps     = (phase % 4 == 0 || phase % 4 == 1) && phase < 8;
                receiver_stalls = (phase % 4 == 0 || phase % 4 == 2) && phase < 8;
                if (phase == 3)
                    long_hold_req = 1'b1;
                if (phase == 5)
                    drain_answers();
            end
            send_request(random_request(phase % 2 == 0));
        end

        req_valid <= 1'b0;
        while (table_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        total = table_sb.kind_count[KIND_REGISTER] + table_sb.kind_count[KIND_UNREGISTER]
              + table_sb.kind_count[KIND_LOOKUP] + table_sb.kind_count[KIND_NTH];
        $display("run: %0d requests (register %0d, unregister %0d, lookup %0d, nth %0d)",
                 total, table_sb.kind_count[KIND_REGISTER],
                 table_sb.kind_count[KIND_UNREGISTER], table_sb.kind_count[KIND_LOOKUP],
                 table_sb.kind_count[KIND_NTH]);
        $display("run: %0d responses checked, %0d full rejects, %0d generation wraps, %0d errors",
                 table_sb.answers_checked, table_sb.full_rejects,
                 table_sb.generation_wraps, table_sb.mismatches);
        if (table_sb.mismatches == 0 && table_sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/ght_pkg.sv
rtl/ght_mem.sv
rtl/generational_handle_table.sv
bench/generational_handle_table_tb.sv
